// ===== hdl/arlt_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the address range lock table.
// Used by arlt_ctrl, arlt_datapath and address_range_lock_table; depends on nothing.
package arlt_pkg;

   localparam int ENTRIES   = 16;
   localparam int ADDR_BITS = 32;
   localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W     = $clog2(ENTRIES + 1);
   localparam int HELD_W    = 5;
   localparam int STATUS_W  = 3;
   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 8;

   typedef enum logic {
      REQ_LOCK   = 1'b0,
      REQ_UNLOCK = 1'b1
   } req_kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_GRANTED   = 3'd0,
      ST_CONFLICT  = 3'd1,
      ST_FULL      = 3'd2,
      ST_ZERO_LEN  = 3'd3,
      ST_NOT_FOUND = 3'd4
   } status_type;

   typedef enum logic {
      CTRL_IDLE = 1'b0,
      CTRL_EXEC = 1'b1
   } ctrl_state_type;

   typedef struct packed {
      logic capture;
      logic commit;
   } dp_cmd_type;

endpackage

// ===== hdl/address_range_lock_table.sv =====
`timescale 1ns / 1ps
// Top level of the address range lock table.
// Depends on arlt_pkg, arlt_ctrl and arlt_datapath.

// The block holds up to 16 non-overlapping half-open address ranges. A lock
// item (tuser low) is granted and stored in the lowest free entry unless its
// length is zero, it overlaps a held range, or the table is full; an unlock
// item (tuser high) frees the range that begins at the given start. Each item
// gives one result item with a status code and the number of ranges held
// afterwards. The request and its end address are first registered; then the
// range is compared against all entries at once and the table is updated.
// The result then waits in an output register while the next item is already
// taken in; that item commits only once the waiting result has been taken.
module address_range_lock_table
   import arlt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // range_start[31:0], range_length[63:32]
   input  logic                  req_tuser,  // req_type: 0 lock, 1 unlock
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata   // status[2:0], held_total[7:3]
);

   dp_cmd_type cmd;

   arlt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   arlt_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tdata (rsp_tdata)
   );

endmodule

// ===== hdl/arlt_ctrl.sv =====
`timescale 1ns / 1ps
// Controller for the address range lock table: handshakes and sequencing.
// Depends on arlt_pkg; drives the command struct of arlt_datapath.
module arlt_ctrl
   import arlt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output dp_cmd_type cmd
);

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CTRL_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      req_tready  = 1'b0;
      cmd.capture = 1'b0;
      cmd.commit  = 1'b0;
      case (state_ff)
         CTRL_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
            if (req_tvalid) begin
               state_in = CTRL_EXEC;
            end
         end
         CTRL_EXEC: begin
            // The table is updated only when the output register can take the result.
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.commit = 1'b1;
               state_in   = CTRL_IDLE;
            end
         end
         default: begin
            state_in = CTRL_IDLE;
         end
      endcase

      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

// ===== hdl/arlt_datapath.sv =====
`timescale 1ns / 1ps
// Datapath for the address range lock table: request registers, entry table,
// parallel overlap compare, free-entry pick and result register. Depends on arlt_pkg.
module arlt_datapath
   import arlt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  dp_cmd_type            cmd,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tuser,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   // Captured request.
   req_kind_type         kind_ff;
   logic [ADDR_BITS-1:0] first_ff;
   logic [ADDR_BITS:0]   limit_ff, limit_in;
   logic                 zero_ff;

   // Entry table.
   logic [ENTRIES-1:0]   entry_valid_ff;
   logic [ADDR_BITS-1:0] entry_first_ff [ENTRIES];
   logic [ADDR_BITS:0]   entry_limit_ff [ENTRIES];
   logic [CNT_W-1:0]     held_ff;

   // Result register.
   status_type           rsp_status_ff;
   logic [HELD_W-1:0]    rsp_held_ff;

   logic [ENTRIES-1:0]   overlap;
   logic [ENTRIES-1:0]   match;
   logic                 free_found, match_found;
   logic [IDX_W-1:0]     free_idx, match_idx;
   status_type           status_in;
   logic                 write_en, clear_en;
   logic [CNT_W-1:0]     held_in;

   assign limit_in = {1'b0, req_tdata[ADDR_BITS-1:0]} + {1'b0, req_tdata[32 +: ADDR_BITS]};

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff  <= req_kind_type'(req_tuser);
         first_ff <= req_tdata[ADDR_BITS-1:0];
         limit_ff <= limit_in;
         zero_ff  <= (req_tdata[32 +: ADDR_BITS] == '0);
      end
   end

   // Two ranges overlap when each starts before the other ends.
   always_comb begin
      free_found  = 1'b0;
      match_found = 1'b0;
      free_idx    = '0;
      match_idx   = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         overlap[i] = entry_valid_ff[i] && ({1'b0, entry_first_ff[i]} < limit_ff)
                      && ({1'b0, first_ff} < entry_limit_ff[i]);
         match[i]   = entry_valid_ff[i] && (entry_first_ff[i] == first_ff);
         if (!entry_valid_ff[i] && !free_found) begin
            free_found = 1'b1;
            free_idx   = IDX_W'(i);
         end
         if (match[i] && !match_found) begin
            match_found = 1'b1;
            match_idx   = IDX_W'(i);
         end
      end
   end

   always_comb begin
      write_en = 1'b0;
      clear_en = 1'b0;
      held_in  = held_ff;
      case (kind_ff)
         REQ_LOCK: begin
            if (zero_ff) begin
               status_in = ST_ZERO_LEN;
            end else if (|overlap) begin
               status_in = ST_CONFLICT;
            end else if (!free_found) begin
               status_in = ST_FULL;
            end else begin
               status_in = ST_GRANTED;
               write_en  = 1'b1;
               held_in   = held_ff + CNT_W'(1);
            end
         end
         REQ_UNLOCK: begin
            if (match_found) begin
               status_in = ST_GRANTED;
               clear_en  = 1'b1;
               if (held_ff != '0) begin
                  held_in = held_ff - CNT_W'(1);
               end
            end else begin
               status_in = ST_NOT_FOUND;
            end
         end
         default: begin
            status_in = ST_NOT_FOUND;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
         held_ff        <= '0;
      end else if (cmd.commit) begin
         held_ff <= held_in;
         if (write_en) begin
            entry_valid_ff[free_idx] <= 1'b1;
         end
         if (clear_en) begin
            entry_valid_ff[match_idx] <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && write_en) begin
         entry_first_ff[free_idx] <= first_ff;
         entry_limit_ff[free_idx] <= limit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_status_ff <= status_in;
         rsp_held_ff   <= HELD_W'(held_in);
      end
   end

   assign rsp_tdata = {rsp_held_ff, rsp_status_ff};

endmodule
